// File: hw/rtl/p2ba_pkg.sv
// Shared types and constants for the power-of-two bucket allocator.
// Holds beat layouts, command and status codes, and the internal job format.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package p2ba_pkg;

  // Fixed field widths of the external beats
  localparam int SIZE_W    = 11;
  localparam int HANDLE_W  = 10;
  localparam int STATUS_W  = 2;
  localparam int OUT_BKT_W = 3;

  // Internal bucket number: wide enough for up to 16 buckets
  localparam int BKT_W = 4;

  // Smallest block size in bytes (bucket 0)
  localparam int MIN_BLOCK_BYTES = 8;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

  // Request beat
  typedef struct packed {
    logic                command;
    logic [SIZE_W-1:0]   size_bytes;
    logic [HANDLE_W-1:0] block_handle;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  granted_handle;
    logic [OUT_BKT_W-1:0] bucket;
  } rsp_t;

  // Classified request kinds
  typedef enum logic [1:0] {
    K_ALLOC      = 2'd0,
    K_FREE       = 2'd1,
    K_BAD_SIZE   = 2'd2,
    K_BAD_HANDLE = 2'd3
  } kind_t;

  // Job passed from the front to the back through the queue
  typedef struct packed {
    kind_t               kind;
    logic [BKT_W-1:0]    bkt;
    logic [HANDLE_W-1:0] handle;
    logic [HANDLE_W-1:0] idx;
  } job_t;

endpackage

`default_nettype wire

// File: hw/rtl/p2ba_front.sv
// Front stage of the bucket allocator: accepts request beats and classifies them.
// Maps size to bucket, splits a handle into bucket and index, flags bad requests.
// Depends on p2ba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p2ba_front #(
  parameter int NUM_BUCKETS       = 8,
  parameter int BLOCKS_PER_BUCKET = 128
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire p2ba_pkg::req_t req,
  output logic               job_valid,
  output p2ba_pkg::job_t     job,
  input  wire logic          queue_full
);
  import p2ba_pkg::*;

  localparam logic [31:0] SIZE_LIMIT = 32'(1) << (NUM_BUCKETS + 2);
  localparam logic [31:0] TOTAL_W    = 32'(NUM_BUCKETS * BLOCKS_PER_BUCKET);

  logic        fvalid;
  logic        accept;
  logic        push;
  job_t        cls;
  logic        bad_size;
  logic        bad_handle;
  logic [31:0] size_w;
  logic [31:0] hdl_w;
  logic [31:0] base;
  logic [BKT_W-1:0] sz_bkt;
  logic [BKT_W-1:0] h_bkt;

  assign accept    = req_valid && !req_stall;
  assign push      = fvalid && !queue_full;
  assign req_stall = fvalid && queue_full;
  assign job_valid = fvalid;

  // Classify the incoming beat
  always_comb begin
    size_w     = {21'd0, req.size_bytes};
    hdl_w      = {22'd0, req.block_handle};
    bad_size   = (req.size_bytes == '0) || (size_w > SIZE_LIMIT);
    bad_handle = hdl_w >= TOTAL_W;

    // smallest class whose block holds the size; compares are monotonic
    sz_bkt = '0;
    for (int k = 0; k < NUM_BUCKETS - 1; k++) begin
      if ((32'(MIN_BLOCK_BYTES) << k) < size_w) begin
        sz_bkt = BKT_W'(k + 1);
      end
    end

    // bucket of a handle: highest bucket base not above it
    h_bkt = '0;
    base  = '0;
    for (int k = 1; k < NUM_BUCKETS; k++) begin
      if (hdl_w >= 32'(k * BLOCKS_PER_BUCKET)) begin
        h_bkt = BKT_W'(k);
        base  = 32'(k * BLOCKS_PER_BUCKET);
      end
    end

    cls.handle = req.block_handle;
    cls.idx    = HANDLE_W'(hdl_w - base);
    if (req.command == CMD_ALLOC) begin
      cls.kind = bad_size ? K_BAD_SIZE : K_ALLOC;
      cls.bkt  = bad_size ? '0 : sz_bkt;
    end else begin
      cls.kind = bad_handle ? K_BAD_HANDLE : K_FREE;
      cls.bkt  = bad_handle ? '0 : h_bkt;
    end
  end

  // Holding register for one classified beat
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= accept || (fvalid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= cls;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/p2ba_queue.sv
// Small FIFO of classified jobs between the allocator front and back.
// Lets either side stall without holding up the other.
// Depends on p2ba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p2ba_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire p2ba_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output p2ba_pkg::job_t      pop_job
);
  import p2ba_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = count == CW'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_job   = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/p2ba_back.sv
// Back stage of the bucket allocator: carries out allocate and free jobs.
// Holds list heads, free counts, fill marks and the per-block link/in-use memory.
// Depends on p2ba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p2ba_back #(
  parameter int NUM_BUCKETS       = 8,
  parameter int BLOCKS_PER_BUCKET = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire p2ba_pkg::job_t job,
  output logic                job_pop,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output p2ba_pkg::rsp_t      rsp
);
  import p2ba_pkg::*;

  localparam int IW    = $clog2(BLOCKS_PER_BUCKET);
  localparam int CW    = IW + 1;
  localparam int TOTAL = NUM_BUCKETS * BLOCKS_PER_BUCKET;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [CW-1:0] BPB_C  = CW'(BLOCKS_PER_BUCKET);
  localparam logic [IW-1:0] LAST_I = IW'(BLOCKS_PER_BUCKET - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t        state;
  job_t          cur;
  logic [IW:0]   rd_data;       // {in_use, link}
  logic [IW-1:0] head  [NUM_BUCKETS];
  logic [CW-1:0] cnt   [NUM_BUCKETS];
  logic [CW-1:0] hw    [NUM_BUCKETS];  // blocks at or above this index never touched
  logic [IW:0]   mem   [TOTAL];

  logic [BW-1:0] qb;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] cb;
  logic [CW-1:0] sel_cnt;
  logic [CW-1:0] sel_hw;
  logic [IW-1:0] sel_head;
  logic [AW-1:0] base_c;
  logic [AW-1:0] alloc_addr;
  logic          fresh_a;
  logic [IW-1:0] link;
  logic [IW-1:0] fidx;
  logic          fresh_f;
  logic          ok_f;
  logic          fire;
  logic          do_alloc;
  logic          do_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [IW:0]   wr_data;
  rsp_t          res;

  // Issue side: take a job and start the memory read
  assign job_pop = (state == S_IDLE) && job_valid;
  assign qb      = BW'(job.bkt);
  always_comb begin
    if (job.kind == K_ALLOC) begin
      rd_addr = AW'(32'(job.bkt) * BLOCKS_PER_BUCKET) + AW'(head[qb]);
    end else begin
      rd_addr = AW'(job.handle);
    end
  end

  // Execute side: per-bucket state of the current job
  assign cb         = BW'(cur.bkt);
  assign sel_cnt    = cnt[cb];
  assign sel_hw     = hw[cb];
  assign sel_head   = head[cb];
  assign base_c     = AW'(32'(cur.bkt) * BLOCKS_PER_BUCKET);
  assign alloc_addr = base_c + AW'(sel_head);

  // Untouched blocks still carry their reset link and are free
  assign fresh_a = {1'b0, sel_head} >= sel_hw;
  assign link    = fresh_a ? ((sel_head == LAST_I) ? '0 : sel_head + 1'b1)
                           : rd_data[IW-1:0];
  assign fidx    = IW'(cur.idx);
  assign fresh_f = {1'b0, fidx} >= sel_hw;
  assign ok_f    = !fresh_f && rd_data[IW] && (sel_cnt < BPB_C);

  assign fire = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // Result and update decision
  always_comb begin
    res      = '0;
    do_alloc = 1'b0;
    do_free  = 1'b0;
    unique case (cur.kind)
      K_BAD_SIZE: begin
        res.status = ST_BAD_SIZE;
      end
      K_BAD_HANDLE: begin
        res.status = ST_BAD_FREE;
      end
      K_ALLOC: begin
        res.bucket = OUT_BKT_W'(cur.bkt);
        if (sel_cnt == '0) begin
          res.status = ST_EXHAUSTED;
        end else begin
          res.status         = ST_OK;
          res.granted_handle = HANDLE_W'(alloc_addr);
          do_alloc           = 1'b1;
        end
      end
      K_FREE: begin
        res.bucket = OUT_BKT_W'(cur.bkt);
        if (ok_f) begin
          res.status = ST_OK;
          do_free    = 1'b1;
        end else begin
          res.status = ST_BAD_FREE;
        end
      end
      default: begin
        res.status = ST_BAD_FREE;
      end
    endcase
  end

  // Memory write port
  always_comb begin
    wr_en   = fire && (do_alloc || do_free);
    wr_addr = do_alloc ? alloc_addr : AW'(cur.handle);
    wr_data = do_alloc ? {1'b1, link} : {1'b0, sel_head};
  end

  // Link / in-use memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (job_pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Current job register
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

  // Sequencer, bucket state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head[b] <= '0;
        cnt[b]  <= BPB_C;
        hw[b]   <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (fire && do_alloc) begin
        head[cb] <= link;
        cnt[cb]  <= sel_cnt - 1'b1;
        if (fresh_a) begin
          hw[cb] <= sel_hw + 1'b1;
        end
      end else if (fire && do_free) begin
        head[cb] <= fidx;
        cnt[cb]  <= sel_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= res;
    end
  end

  // Free count never exceeds the bucket size
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (sel_cnt <= BPB_C))
    else $error("free count above bucket size");

  // Fill mark never passes the bucket size
  a_hw_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (sel_hw <= BPB_C))
    else $error("fill mark above bucket size");

  // Every untouched block is counted as free
  a_fresh_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> ((32'(sel_cnt) + 32'(sel_hw)) >= 32'(BLOCKS_PER_BUCKET)))
    else $error("free count below untouched blocks");

  // A failed request never grants a handle
  a_fail_no_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.granted_handle == '0))
    else $error("handle granted on failure");

endmodule

`default_nettype wire

// File: hw/rtl/power_of_two_bucket_allocator_unit.sv
// Power-of-two bucket allocator: top level joining front, queue and back.
// Depends on p2ba_pkg, p2ba_front, p2ba_queue and p2ba_back.
//
// Use: requests enter on req (req_valid / req_stall); a beat is taken at a
// rising edge with req_valid high and req_stall low. Each request gives one
// response beat on rsp (rsp_valid / rsp_stall), in request order. Allocate
// pops the head block of the size class that fits size_bytes; free pushes
// block_handle back on its class list. Errors come back as status codes.
// A taken beat is held in the front register, passes the queue and then
// the back stage, which feeds the response register. The back stage takes
// no new job until it is through with the last: it reads the link/in-use
// memory, then updates it and the list head of the bucket. The two-entry
// queue lets the front keep taking beats while the back waits on a stalled
// response; the response register holds its beat until rsp_stall drops.
// Reset (rst, synchronous) empties the pipeline and restores all lists at
// once: per-bucket fill marks stand in for the reset contents of the block
// memory, so there is no clearing pass before requests are accepted.
`timescale 1ns / 1ps
`default_nettype none

module power_of_two_bucket_allocator_unit #(
  parameter int NUM_BUCKETS       = 8,
  parameter int BLOCKS_PER_BUCKET = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire p2ba_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output p2ba_pkg::rsp_t      rsp
);
  import p2ba_pkg::*;

  logic job_valid;
  job_t job;
  logic queue_full;
  logic q_valid;
  job_t q_job;
  logic q_pop;

  p2ba_front #(
    .NUM_BUCKETS       (NUM_BUCKETS),
    .BLOCKS_PER_BUCKET (BLOCKS_PER_BUCKET)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .job_valid  (job_valid),
    .job        (job),
    .queue_full (queue_full)
  );

  p2ba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_job  (job),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  p2ba_back #(
    .NUM_BUCKETS       (NUM_BUCKETS),
    .BLOCKS_PER_BUCKET (BLOCKS_PER_BUCKET)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: bench/power_of_two_bucket_allocator_unit_tb.sv
// Self-checking bench for the power-of-two bucket allocator top level.
// Drives request beats, tracks the free lists and flags every response that strays.
// Depends on p2ba_pkg and power_of_two_bucket_allocator_unit.
`timescale 1ns / 1ps

module power_of_two_bucket_allocator_unit_tb;
  import p2ba_pkg::*;

  localparam int NB           = 8;
  localparam int BPB          = 128;
  localparam int POOL         = NB * BPB;
  localparam int SIZE_LIMIT   = 1 << (NB + 2);
  localparam int RANDOM_ITEMS = 2000;
  localparam int LIMIT        = 1000000;
  localparam int SETTLE       = 20;

  typedef enum int {MIX_ALLOC, MIX_FREE, MIX_EVEN, MIX_NOISE} traffic_t;

  // Free-list tracker and response checker
  class grant_scoreboard;
    logic [6:0]          link_of [POOL];
    logic [6:0]          head_of [NB];
    logic [7:0]          free_in [NB];
    bit                  taken [POOL];
    rsp_t                awaited [$];
    logic [HANDLE_W-1:0] held [$];
    int                  errors;

    function new();
      errors = 0;
      for (int b = 0; b < NB; b++) begin
        head_of[b] = '0;
        free_in[b] = 8'(BPB);
        for (int i = 0; i < BPB; i++) begin
          link_of[b*BPB + i] = 7'((i + 1 < BPB) ? i + 1 : 0);
          taken[b*BPB + i]   = 1'b0;
        end
      end
    endfunction

    function int unsigned size_class(logic [SIZE_W-1:0] size);
      int unsigned b;
      b = 0;
      while (b + 1 < NB && (MIN_BLOCK_BYTES << b) < size) b++;
      return b;
    endfunction

    // Apply one request to the lists and return the beat it must produce
    function rsp_t grant_for(req_t r);
      rsp_t        o;
      int unsigned b, idx, blk;
      int          found [$];
      o = '0;
      if (r.command == CMD_ALLOC) begin
        if (r.size_bytes == 0 || r.size_bytes > SIZE_LIMIT) begin
          o.status = ST_BAD_SIZE;
        end else begin
          b = size_class(r.size_bytes);
          o.bucket = b[OUT_BKT_W-1:0];
          if (free_in[b] == 0) begin
            o.status = ST_EXHAUSTED;
          end else begin
            idx = 32'(head_of[b]);
            blk = b * BPB + idx;
            taken[blk] = 1'b1;
            head_of[b] = link_of[blk];
            free_in[b] = free_in[b] - 8'd1;
            o.status = ST_OK;
            o.granted_handle = blk[HANDLE_W-1:0];
            held.push_back(blk[HANDLE_W-1:0]);
          end
        end
      end else begin
        if (r.block_handle >= POOL) begin
          o.status = ST_BAD_FREE;
        end else begin
          b = r.block_handle / BPB;
          idx = r.block_handle % BPB;
          o.bucket = b[OUT_BKT_W-1:0];
          if (!taken[r.block_handle] || free_in[b] >= BPB) begin
            o.status = ST_BAD_FREE;
          end else begin
            taken[r.block_handle] = 1'b0;
            link_of[r.block_handle] = head_of[b];
            head_of[b] = idx[6:0];
            free_in[b] = free_in[b] + 8'd1;
            o.status = ST_OK;
            found = held.find_first_index(x) with (x == r.block_handle);
            if (found.size() > 0) held.delete(found[0]);
          end
        end
      end
      return o;
    endfunction

    function void note_request(req_t r);
      awaited.push_back(grant_for(r));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing awaited (status %0d)",
                                  got.status));
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.granted_handle !== want.granted_handle)
          report_mismatch($sformatf("granted_handle %0d, want %0d",
                                    got.granted_handle, want.granted_handle));
        if (got.bucket !== want.bucket)
          report_mismatch($sformatf("bucket %0d, want %0d", got.bucket, want.bucket));
      end
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  grant_scoreboard sb = new();
  bit              send_calm = 1'b0;
  int              cycles = 0;

  power_of_two_bucket_allocator_unit #(
    .NUM_BUCKETS(NB),
    .BLOCKS_PER_BUCKET(BPB)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Response side: check accepted beats, stall in random runs with calm stretches
  int  stall_run = 0;
  int  phase_left = 0;
  bit  rsp_calm = 1'b0;
  always @(posedge clk) begin
    int roll;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (phase_left == 0) begin
        rsp_calm = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 400);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (stall_run > 0) begin
        stall_run--;
      end else if (!rsp_calm) begin
        if (roll < 25) stall_run = $urandom_range(1, 3);
        else if (roll < 28) stall_run = $urandom_range(10, 40);
      end
      rsp_stall <= (stall_run > 0);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (send_calm || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t beat_of(logic cmd, int unsigned size, int unsigned handle);
    req_t r;
    r.command = cmd;
    r.size_bytes = size[SIZE_W-1:0];
    r.block_handle = handle[HANDLE_W-1:0];
    return r;
  endfunction

  // A size that lands in class b, edges favored
  function automatic int unsigned size_in(int unsigned b);
    int unsigned lo, hi, roll;
    lo = (b == 0) ? 1 : (MIN_BLOCK_BYTES << (b - 1)) + 1;
    hi = MIN_BLOCK_BYTES << b;
    roll = $urandom_range(0, 9);
    if (roll < 2) return lo;
    if (roll < 4) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic req_t alloc_beat(int unsigned b);
    return beat_of(CMD_ALLOC, size_in(b), $urandom_range(0, POOL - 1));
  endfunction

  // Free a held block mostly, a stray handle otherwise
  function automatic req_t free_beat();
    int unsigned h;
    if (sb.held.size() > 0 && $urandom_range(0, 99) < 80)
      h = 32'(sb.held[$urandom_range(0, sb.held.size() - 1)]);
    else
      h = $urandom_range(0, POOL - 1);
    return beat_of(CMD_FREE, $urandom_range(0, (1 << SIZE_W) - 1), h);
  endfunction

  function automatic req_t next_beat(traffic_t mode, int unsigned focus);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MIX_ALLOC: begin
        if (roll < 85) return alloc_beat(focus);
        if (roll < 95) return alloc_beat($urandom_range(0, NB - 1));
        return free_beat();
      end
      MIX_FREE: begin
        if (roll < 80) return free_beat();
        return alloc_beat($urandom_range(0, NB - 1));
      end
      MIX_EVEN: begin
        if (roll < 50) return free_beat();
        return alloc_beat($urandom_range(0, NB - 1));
      end
      default: return req_t'($urandom);
    endcase
  endfunction

  // Present one beat and hold it until it is taken
  task automatic send_request(input req_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(beat);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    traffic_t    mode;
    int unsigned focus, len, sent, roll;
    bit          drained_mid;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: size edges, every class, LIFO reuse, bad frees
    send_request(beat_of(CMD_ALLOC, 0, 0));
    send_request(beat_of(CMD_ALLOC, 2047, 1023));
    send_request(beat_of(CMD_ALLOC, SIZE_LIMIT + 1, 0));
    send_request(beat_of(CMD_ALLOC, 1, 0));
    send_request(beat_of(CMD_ALLOC, 8, 0));
    send_request(beat_of(CMD_ALLOC, 9, 0));
    send_request(beat_of(CMD_ALLOC, 17, 0));
    send_request(beat_of(CMD_ALLOC, 33, 0));
    send_request(beat_of(CMD_ALLOC, 65, 0));
    send_request(beat_of(CMD_ALLOC, 129, 0));
    send_request(beat_of(CMD_ALLOC, 257, 0));
    send_request(beat_of(CMD_ALLOC, SIZE_LIMIT, 0));
    send_request(beat_of(CMD_ALLOC, 513, 0));
    send_request(beat_of(CMD_FREE, 0, POOL - 1));
    send_request(beat_of(CMD_FREE, 0, 0));
    send_request(beat_of(CMD_FREE, 0, 0));
    send_request(beat_of(CMD_ALLOC, 4, 0));
    send_request(beat_of(CMD_FREE, 0, 7 * BPB + 1));
    send_request(beat_of(CMD_FREE, 0, 7 * BPB));
    send_request(beat_of(CMD_ALLOC, 600, 0));
    send_request(beat_of(CMD_FREE, 2047, 5));
    send_request(beat_of(CMD_ALLOC, 16, POOL - 1));
    send_request(beat_of(CMD_FREE, 0, BPB));
    send_request(beat_of(CMD_FREE, 2047, BPB));
    drain();

    // Random bursts: fill one class, free back, mix, or raw noise
    sent = 0;
    drained_mid = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      focus = $urandom_range(0, NB - 1);
      send_calm = ($urandom_range(0, 4) == 0);
      if (roll < 35) begin
        mode = MIX_ALLOC;
        len = $urandom_range(150, 260);
      end else if (roll < 65) begin
        mode = MIX_FREE;
        len = sb.held.size() + $urandom_range(10, 40);
      end else if (roll < 90) begin
        mode = MIX_EVEN;
        len = $urandom_range(50, 150);
      end else begin
        mode = MIX_NOISE;
        len = $urandom_range(10, 30);
      end
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        send_request(next_beat(mode, focus));
        sent++;
      end
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        drain();
        drained_mid = 1'b1;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
